// ----- src/icmp_rm_pkg.sv -----
package icmp_rm_pkg;

  localparam int unsigned POS_W  = 8;
  localparam int unsigned HB_W   = 6;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned CFG_W  = 16;

  localparam logic [7:0]       TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0]       TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0]       ICMP_HDR_BYTES     = 8'd8;
  localparam logic [7:0]       IDENT_OFFSET       = 8'd4;
  localparam logic [HB_W-1:0]  MIN_HDR_BYTES      = 6'd20;
  localparam logic [SUM_W-1:0] SUM_GOOD           = 16'hffff;
  localparam logic [POS_W-1:0] POS_MAX            = 8'd255;
  localparam logic [POS_W-1:0] SRC_FIRST          = 8'd12;
  localparam logic [POS_W-1:0] SRC_LAST           = 8'd15;

  typedef enum logic [1:0] {
    VERDICT_NOT_MINE  = 2'd0,
    VERDICT_ACCEPTED  = 2'd1,
    VERDICT_REJECTED  = 2'd2,
    VERDICT_MALFORMED = 2'd3
  } verdict_t;

  typedef enum logic {
    REG_ECHO_IDENT  = 1'b0,
    REG_SENT_WORDS  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    IDENT_NONE = 2'd0,
    IDENT_HIGH = 2'd1,
    IDENT_FULL = 2'd2,
    IDENT_RSVD = 2'd3
  } ident_seen_t;

  // per-packet parse state
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [HB_W-1:0]  hdr_bytes;
    logic [SUM_W-1:0] sum;
    logic [7:0]       high_hold;
    logic [7:0]       outer_type;
    logic [15:0]      found_ident;
    ident_seen_t      ident_seen;
    logic [31:0]      source;
  } parse_state_t;

endpackage

// ----- src/icmp_rm_step.sv -----
module icmp_rm_step (
  input  icmp_rm_pkg::parse_state_t st,
  input  logic [7:0]                byte_in,
  input  logic [15:0]               echo_ident,
  input  logic [3:0]                sent_words,
  output icmp_rm_pkg::parse_state_t st_nxt,
  output icmp_rm_pkg::verdict_t     verdict
);

  logic [5:0]  hb_eff;
  logic [7:0]  hb_ext;
  logic [16:0] sum_raw;
  logic [15:0] sum_fold;
  logic [7:0]  base;
  logic [7:0]  quote_skip;

  always_comb begin
    st_nxt = st;

    // IHL is taken from the very first byte
    hb_eff = (st.pos == '0) ? {byte_in[3:0], 2'b00} : st.hdr_bytes;
    hb_ext = {2'b00, hb_eff};
    st_nxt.hdr_bytes = hb_eff;

    // header checksum, carry folded after every word
    sum_raw  = {1'b0, st.sum} + {1'b0, st.high_hold, byte_in};
    sum_fold = sum_raw[15:0] + {15'd0, sum_raw[16]};
    if (st.pos < hb_ext) begin
      if (!st.pos[0]) begin
        st_nxt.high_hold = byte_in;
      end else begin
        st_nxt.sum = sum_fold;
      end
    end

    if (st.pos >= icmp_rm_pkg::SRC_FIRST && st.pos <= icmp_rm_pkg::SRC_LAST) begin
      st_nxt.source = {st.source[23:0], byte_in};
    end

    if (st.pos == hb_ext) begin
      st_nxt.outer_type = byte_in;
    end

    // non-echo replies carry the identifier inside the quoted probe
    quote_skip = icmp_rm_pkg::ICMP_HDR_BYTES + {2'b00, sent_words, 2'b00};
    base = hb_ext + icmp_rm_pkg::IDENT_OFFSET +
           ((st.outer_type != icmp_rm_pkg::TYPE_ECHO_REPLY) ? quote_skip : 8'd0);
    if (st.pos > hb_ext) begin
      if (st.pos == base) begin
        st_nxt.found_ident = {byte_in, 8'd0};
        st_nxt.ident_seen  = icmp_rm_pkg::IDENT_HIGH;
      end else if (st.pos == base + 8'd1 && st.ident_seen == icmp_rm_pkg::IDENT_HIGH) begin
        st_nxt.found_ident = {st.found_ident[15:8], byte_in};
        st_nxt.ident_seen  = icmp_rm_pkg::IDENT_FULL;
      end
    end

    if (st.pos != icmp_rm_pkg::POS_MAX) begin
      st_nxt.pos = st.pos + 8'd1;
    end

    priority if (hb_eff < icmp_rm_pkg::MIN_HDR_BYTES ||
                 st_nxt.ident_seen != icmp_rm_pkg::IDENT_FULL) begin
      verdict = icmp_rm_pkg::VERDICT_MALFORMED;
    end else if (st_nxt.found_ident != echo_ident) begin
      verdict = icmp_rm_pkg::VERDICT_NOT_MINE;
    end else if (st_nxt.sum == icmp_rm_pkg::SUM_GOOD &&
                 (st_nxt.outer_type == icmp_rm_pkg::TYPE_ECHO_REPLY ||
                  st_nxt.outer_type == icmp_rm_pkg::TYPE_TIME_EXCEEDED)) begin
      verdict = icmp_rm_pkg::VERDICT_ACCEPTED;
    end else begin
      verdict = icmp_rm_pkg::VERDICT_REJECTED;
    end
  end

endmodule

// ----- src/icmp_reply_matcher.sv -----
// channel | dir | tdata (low bit up)                                  | tuser | tlast
// in_     | in  | [7:0] byte_value                                    | -     | last_byte
// out_    | out | [1:0] verdict, [9:2] reply_type, [41:10] source_address, pad | -  | -
// cfg_    | in  | cfg_index 0 echo_ident, 1 sent_header_words; cfg_data 16 bits
//
// One byte per cycle unless a last byte is stalled; a byte waits in the input register,
// then the parse state and, on the last byte, the result register are updated.
// The result register is loaded as its last byte leaves the input register.
// rst_n (synchronous) clears the parse state and both valid flags; echo_ident resets to 0, sent_header_words to 5.
// A result held by out_tready stalls only a last byte in the input register;
// other bytes keep flowing meanwhile.
module icmp_reply_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [1:0] verdict, [9:2] reply_type, [41:10] source_address
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] echo_ident_r;
  logic [3:0]  sent_words_r;

  logic        s1_valid_r;
  logic        s1_last_r;
  logic [7:0]  s1_byte_r;
  logic        s1_adv;

  icmp_rm_pkg::parse_state_t st_r;
  icmp_rm_pkg::parse_state_t st_step;
  icmp_rm_pkg::verdict_t     verdict;

  logic        out_valid_r;
  logic [41:0] out_data_r;

  icmp_rm_step u_step (
    .st         (st_r),
    .byte_in    (s1_byte_r),
    .echo_ident (echo_ident_r),
    .sent_words (sent_words_r),
    .st_nxt     (st_step),
    .verdict    (verdict)
  );

  // last byte may only leave when the result slot is free or being emptied
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_ident_r <= '0;
      sent_words_r <= 4'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        icmp_rm_pkg::REG_ECHO_IDENT: echo_ident_r <= cfg_data;
        icmp_rm_pkg::REG_SENT_WORDS: sent_words_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      st_r <= s1_last_r ? '0 : st_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_data_r <= {st_step.source, st_step.outer_type, verdict};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

  a_clear_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> st_r.pos == '0)
    else $error("parse state not cleared after last item");

  a_state_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(st_r))
    else $error("parse state moved without an item");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && s1_last_r && out_valid_r && !out_tready)
    else $error("input stalled without a waiting result");

  a_result_from_last : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result produced without a last item");

endmodule
